// ----- hdl/bffl_pkg.sv -----
// Shared types and constants for the best-fit free list.
// Used by bffl_cell and best_fit_free_list; depends on nothing else.
`timescale 1ns / 1ps

package bffl_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int POS_W       = 32;
  localparam int SIZE_W      = 30;
  localparam int RANK_W      = 8;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TAKE   = 2'd2,
    CMD_IGNORE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_FULL  = 2'd2,
    ST_DUP   = 2'd3
  } status_t;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [SIZE_W-1:0] size;
    logic [RANK_W-1:0] rank;
  } entry_t;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic active;   // the captured command is being executed this cycle
    cmd_t op;
    logic ins_ok;   // sorted insert may write (table not full)
    logic app_ok;   // append may write (no duplicate, not full)
    logic take_ok;  // take found a hole and removes it
  } cell_ctrl_t;

endpackage

// ----- hdl/bffl_cell.sv -----
// One slot of the sorted hole chain: holds one entry and its match logic.
// Depends on bffl_pkg.
`timescale 1ns / 1ps

module bffl_cell (
  input  logic                     clk,
  input  bffl_pkg::cell_ctrl_t     ctrl,
  input  logic                     valid,
  input  logic                     is_tail,
  input  logic                     found_in,
  input  bffl_pkg::entry_t         req,
  input  bffl_pkg::entry_t         prev_ent,
  input  bffl_pkg::entry_t         next_ent,
  output logic                     found_out,
  output logic [bffl_pkg::POS_W-1:0] sel_pos,
  output bffl_pkg::entry_t         ent
);
  import bffl_pkg::*;

  logic   mark;
  logic   first;
  logic   load;
  entry_t ent_next;

  // Per-command match condition of this slot.
  always_comb begin
    case (ctrl.op)
      CMD_INSERT: mark = is_tail ||
                         (valid && ((ent.size > req.size) ||
                                    ((ent.size == req.size) && (ent.rank <= req.rank))));
      CMD_APPEND: mark = valid && (ent.pos == req.pos);
      CMD_TAKE:   mark = valid && (ent.size >= req.size);
      default:    mark = 1'b0;
    endcase
  end

  assign first     = mark && !found_in;
  assign found_out = found_in || mark;
  assign sel_pos   = first ? ent.pos : '0;

  always_comb begin
    load     = 1'b0;
    ent_next = ent;
    if (ctrl.active) begin
      case (ctrl.op)
        CMD_INSERT: begin
          if (ctrl.ins_ok && first) begin
            load     = 1'b1;
            ent_next = req;
          end else if (ctrl.ins_ok && found_in) begin
            load     = 1'b1;
            ent_next = prev_ent;
          end
        end
        CMD_APPEND: begin
          if (ctrl.app_ok && is_tail) begin
            load     = 1'b1;
            ent_next = req;
          end
        end
        CMD_TAKE: begin
          if (ctrl.take_ok && found_out) begin
            load     = 1'b1;
            ent_next = next_ent;
          end
        end
        default: begin
          load = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ent <= ent_next;
    end
  end

endmodule

// ----- hdl/best_fit_free_list.sv -----
// Top level of the best-fit free list: command capture, hole count and results.
// Depends on bffl_pkg and bffl_cell.
`timescale 1ns / 1ps

//  Channel   Ports                               Handshake
//  command   cmd, pos, size, priority_req        start high while busy low
//  result    status, found_pos                   done high for one cycle
//
// The transfer edge captures each command, and in the next cycle every cell
// compares its entry at once, the first-match flag ripples down the row of
// cells, and on insert or take the row shifts by one slot. The result
// appears with done in the cycle after that, when busy is already low, so a
// new command can be taken while the last result is shown. Capture and
// execution never overlap, and the ripple fits inside the execute cycle.
// Reset clears the hole count and the handshake state; entries are not
// cleared, since only slots below the count are ever used. The receiver
// cannot stall: done flags each result for exactly one cycle.

module best_fit_free_list (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  cmd,
  input  logic [bffl_pkg::POS_W-1:0]  pos,
  input  logic [bffl_pkg::SIZE_W-1:0] size,
  input  logic [bffl_pkg::RANK_W-1:0] priority_req,
  output logic                        done,
  output logic [1:0]                  status,
  output logic [bffl_pkg::POS_W-1:0]  found_pos
);
  import bffl_pkg::*;

  // Captured command.
  cmd_t              op_cmd;
  logic [POS_W-1:0]  op_pos;
  logic [SIZE_W-1:0] op_size;
  logic [RANK_W-1:0] op_rank;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  status_t           status_next;
  logic [POS_W-1:0]  found_pos_next;

  cell_ctrl_t        ctrl;
  entry_t            req;
  entry_t            ents   [TABLE_DEPTH];
  logic [POS_W-1:0]  sel    [TABLE_DEPTH];
  logic              found  [TABLE_DEPTH+1];
  logic              full;
  logic              any_hit;
  logic [POS_W-1:0]  hit_pos;

  assign full    = (count == CNT_W'(TABLE_DEPTH));
  assign any_hit = found[TABLE_DEPTH];
  assign found[0] = 1'b0;

  // Appended holes always carry rank zero.
  assign req.pos  = op_pos;
  assign req.size = op_size;
  assign req.rank = (op_cmd == CMD_APPEND) ? '0 : op_rank;

  assign ctrl.active  = busy;
  assign ctrl.op      = op_cmd;
  assign ctrl.ins_ok  = !full;
  assign ctrl.app_ok  = !full && !any_hit;
  assign ctrl.take_ok = any_hit;

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      bffl_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .valid     (CNT_W'(gi) < count),
        .is_tail   (CNT_W'(gi) == count),
        .found_in  (found[gi]),
        .req       (req),
        .prev_ent  ((gi == 0) ? req : ents[(gi == 0) ? 0 : gi - 1]),
        .next_ent  ((gi == TABLE_DEPTH - 1) ? ents[gi]
                                            : ents[(gi == TABLE_DEPTH - 1) ? gi : gi + 1]),
        .found_out (found[gi+1]),
        .sel_pos   (sel[gi]),
        .ent       (ents[gi])
      );
    end
  endgenerate

  // At most one cell flags itself as the first match, so an OR picks its position.
  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_pos = hit_pos | sel[i];
    end
  end

  always_comb begin
    count_next     = count;
    status_next    = ST_OK;
    found_pos_next = '0;
    unique case (op_cmd)
      CMD_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      CMD_APPEND: begin
        if (any_hit) begin
          status_next = ST_DUP;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      CMD_TAKE: begin
        if (any_hit) begin
          found_pos_next = hit_pos;
          count_next     = count - CNT_W'(1);
        end else begin
          status_next = ST_NOFIT;
        end
      end
      CMD_IGNORE: begin
        status_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= busy;
      if (busy) begin
        busy  <= 1'b0;
        count <= count_next;
      end else if (start) begin
        busy <= 1'b1;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_cmd  <= cmd_t'(cmd);
      op_pos  <= pos;
      op_size <= size;
      op_rank <= priority_req;
    end
    if (busy) begin
      status    <= status_next;
      found_pos <= found_pos_next;
    end
  end

endmodule
